>>> hw/rtl/opw_pkg.sv
// ----------------------------------------------------------------------------
// opw_pkg
// Shared types and constants for the Ogg page walker.
// ----------------------------------------------------------------------------
package opw_pkg;

	localparam int OFFSET_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [7:0] CHAR_O = 8'h4F;
	localparam logic [7:0] CHAR_G = 8'h67;
	localparam logic [7:0] CHAR_S = 8'h53;

	localparam logic [4:0] HDR_FLAGS = 5'd5;
	localparam logic [4:0] HDR_LAST  = 5'd26;

	localparam logic [1:0] ST_PAGE  = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_CLEAN = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_EOS  = 1'b1
	} kind_t;

	// one classified request
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       is_o;
		logic       is_g;
		logic       is_s;
	} item_t;

	typedef enum logic [3:0] {
		PH_HEADER   = 4'b0001,
		PH_SEGMENTS = 4'b0010,
		PH_PAYLOAD  = 4'b0100,
		PH_ERROR    = 4'b1000
	} phase_t;

endpackage

>>> hw/rtl/opw_front.sv
// ----------------------------------------------------------------------------
// opw_front
// Accepts stream requests, tags end markers and pre-decodes capture bytes.
// ----------------------------------------------------------------------------
module opw_front (
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     data_byte,
	input  logic           end_of_stream,
	input  logic           q_ready,
	output logic           push,
	output opw_pkg::item_t push_item
);

	assign in_ready = q_ready;
	assign push     = in_valid & q_ready;

	always_comb begin
		push_item.kind = end_of_stream ? opw_pkg::KIND_EOS : opw_pkg::KIND_BYTE;
		push_item.data = data_byte;
		push_item.is_o = (data_byte == opw_pkg::CHAR_O);
		push_item.is_g = (data_byte == opw_pkg::CHAR_G);
		push_item.is_s = (data_byte == opw_pkg::CHAR_S);
	end

endmodule

>>> hw/rtl/opw_queue.sv
// ----------------------------------------------------------------------------
// opw_queue
// Short FIFO between the front and the walker.
// ----------------------------------------------------------------------------
module opw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  opw_pkg::item_t push_item,
	output logic           q_ready,
	input  logic           pop,
	output logic           head_valid,
	output opw_pkg::item_t head_item
);

	localparam int PW = (opw_pkg::QUEUE_DEPTH > 1) ? $clog2(opw_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(opw_pkg::QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(opw_pkg::QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_C  = PW'(opw_pkg::QUEUE_DEPTH - 1);

	opw_pkg::item_t  mem_q [opw_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign q_ready    = (count_q != DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/opw_back.sv
// ----------------------------------------------------------------------------
// opw_back
// Page walker state machine with a registered result stage.
// ----------------------------------------------------------------------------
module opw_back #(
	parameter int OFFSET_WIDTH = opw_pkg::OFFSET_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  opw_pkg::item_t head_item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     status,
	output logic [31:0]    page_offset,
	output logic [7:0]     page_flags,
	output logic [7:0]     segment_count,
	output logic [15:0]    payload_size
);

	opw_pkg::phase_t         phase_q, phase_d;
	logic [15:0]             count_q, count_d;
	logic [OFFSET_WIDTH-1:0] offset_q, offset_d;
	logic [OFFSET_WIDTH-1:0] start_q, start_d;
	logic [7:0]              flags_q, flags_d;
	logic [7:0]              segs_q, segs_d;
	logic [15:0]             sum_q, sum_d;

	logic                    out_valid_q;
	logic [1:0]              status_q;
	logic [31:0]             offset_out_q;
	logic [7:0]              flags_out_q;
	logic [7:0]              segs_out_q;
	logic [15:0]             size_out_q;

	logic                    emit;
	logic [1:0]              e_status;
	logic                    e_use_start;
	logic [7:0]              e_flags;
	logic [7:0]              e_segs;
	logic [15:0]             e_size;
	logic [31:0]             offset_now32;
	logic [31:0]             start_now32;
	logic [OFFSET_WIDTH-1:0] start_now;
	logic                    at_boundary;
	logic                    mismatch;
	logic [15:0]             count_inc;
	logic [15:0]             sum_inc;

	assign pop         = head_valid & (~out_valid_q | out_ready);
	assign at_boundary = (phase_q == opw_pkg::PH_HEADER) && (count_q == '0);
	assign start_now   = at_boundary ? offset_q : start_q;
	assign count_inc   = count_q + 16'd1;
	assign sum_inc     = sum_q + {8'd0, head_item.data};

	generate
		if (OFFSET_WIDTH >= 32) begin : g_trunc
			assign offset_now32 = offset_q[31:0];
			assign start_now32  = start_now[31:0];
		end else begin : g_ext
			assign offset_now32 = {{(32-OFFSET_WIDTH){1'b0}}, offset_q};
			assign start_now32  = {{(32-OFFSET_WIDTH){1'b0}}, start_now};
		end
	endgenerate

	always_comb begin
		unique case (count_q[1:0])
			2'd0:    mismatch = ~head_item.is_o;
			2'd3:    mismatch = ~head_item.is_s;
			default: mismatch = ~head_item.is_g;
		endcase
		if (count_q[15:2] != '0) begin
			mismatch = 1'b0;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		offset_d    = offset_q;
		start_d     = start_q;
		flags_d     = flags_q;
		segs_d      = segs_q;
		sum_d       = sum_q;
		emit        = 1'b0;
		e_status    = opw_pkg::ST_PAGE;
		e_use_start = 1'b1;
		e_flags     = 8'd0;
		e_segs      = 8'd0;
		e_size      = 16'd0;

		if (pop && phase_q != opw_pkg::PH_ERROR) begin
			if (head_item.kind == opw_pkg::KIND_EOS) begin
				emit        = 1'b1;
				e_use_start = 1'b0;
				e_status    = at_boundary ? opw_pkg::ST_CLEAN : opw_pkg::ST_TRUNC;
			end else begin
				start_d  = start_now;
				offset_d = offset_q + 1'b1;
				unique case (phase_q)
					opw_pkg::PH_HEADER: begin
						if (mismatch) begin
							phase_d  = opw_pkg::PH_ERROR;
							count_d  = '0;
							emit     = 1'b1;
							e_status = opw_pkg::ST_BAD;
						end else if (count_q == {11'd0, opw_pkg::HDR_LAST}) begin
							segs_d  = head_item.data;
							sum_d   = '0;
							count_d = '0;
							if (head_item.data == 8'd0) begin
								phase_d = opw_pkg::PH_HEADER;
								emit    = 1'b1;
								e_flags = flags_q;
							end else begin
								phase_d = opw_pkg::PH_SEGMENTS;
							end
						end else begin
							if (count_q == {11'd0, opw_pkg::HDR_FLAGS}) begin
								flags_d = head_item.data;
							end
							count_d = count_inc;
						end
					end
					opw_pkg::PH_SEGMENTS: begin
						sum_d   = sum_inc;
						count_d = count_inc;
						if (count_inc >= {8'd0, segs_q}) begin
							phase_d = (sum_inc == '0) ? opw_pkg::PH_HEADER
								: opw_pkg::PH_PAYLOAD;
							count_d = '0;
							emit    = 1'b1;
							e_flags = flags_q;
							e_segs  = segs_q;
							e_size  = sum_inc;
						end
					end
					opw_pkg::PH_PAYLOAD: begin
						count_d = count_inc;
						if (count_inc >= sum_q) begin
							phase_d = opw_pkg::PH_HEADER;
							count_d = '0;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= opw_pkg::PH_HEADER;
			count_q     <= '0;
			offset_q    <= '0;
			start_q     <= '0;
			flags_q     <= '0;
			segs_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			offset_q <= offset_d;
			start_q  <= start_d;
			flags_q  <= flags_d;
			segs_q   <= segs_d;
			sum_q    <= sum_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q     <= e_status;
			offset_out_q <= e_use_start ? start_now32 : offset_now32;
			flags_out_q  <= e_flags;
			segs_out_q   <= e_segs;
			size_out_q   <= e_size;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign page_offset   = offset_out_q;
	assign page_flags    = flags_out_q;
	assign segment_count = segs_out_q;
	assign payload_size  = size_out_q;

endmodule

>>> hw/rtl/ogg_page_walker_core.sv
// ----------------------------------------------------------------------------
// ogg_page_walker_core
// Walks an Ogg byte stream page by page and reports each page header.
// ----------------------------------------------------------------------------
// Takes one stream byte (or an end marker) per cycle while no report waits on
// out_ready, with no gaps between pages: the walker state is updated once per
// byte, so the byte rate is set by that single update loop. A page report is
// registered in the result stage when the walker pops the byte completing its
// segment table; out_valid stalls hold the walker, the queue ahead and in_ready.
// After a bad capture pattern everything is dropped silently until reset.
module ogg_page_walker_core #(
	parameter int OFFSET_WIDTH = opw_pkg::OFFSET_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] page_offset,
	output logic [7:0]  page_flags,
	output logic [7:0]  segment_count,
	output logic [15:0] payload_size
);

	logic           q_ready;
	logic           push;
	opw_pkg::item_t push_item;
	logic           pop;
	logic           head_valid;
	opw_pkg::item_t head_item;

	opw_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.q_ready       (q_ready),
		.push          (push),
		.push_item     (push_item)
	);

	opw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.q_ready    (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	opw_back #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.page_offset   (page_offset),
		.page_flags    (page_flags),
		.segment_count (segment_count),
		.payload_size  (payload_size)
	);

endmodule

>>> tb/sv/ogg_page_walker_core_check.sv
// ----------------------------------------------------------------------------
// ogg_page_walker_core_check
// Watches both channels of the page walker, predicts every page report and
// compares the results in order.
// ----------------------------------------------------------------------------
// Each accepted request goes through a cycle-free model of the walker. Any
// report it produces is queued. Each accepted result is compared field by
// field against the oldest queued report. The mismatch count and the number
// of reports still waiting are handed to the testbench top.
module ogg_page_walker_core_check #(
	parameter int OFFSET_WIDTH = opw_pkg::OFFSET_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [31:0] page_offset,
	input  logic [7:0]  page_flags,
	input  logic [7:0]  segment_count,
	input  logic [15:0] payload_size,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] offset;
		logic [7:0]  flags;
		logic [7:0]  segs;
		logic [15:0] size;
	} page_report_t;

	page_report_t            reports_due[$];
	opw_pkg::phase_t         walk_phase;
	logic [15:0]             phase_bytes;
	logic [OFFSET_WIDTH-1:0] byte_offset;
	logic [OFFSET_WIDTH-1:0] page_base;
	logic [7:0]              held_flags;
	logic [7:0]              held_segs;
	logic [15:0]             lace_total;
	int                      mismatch_count;

	function automatic page_report_t make_report(input logic [1:0] st,
			input logic [OFFSET_WIDTH-1:0] off, input logic [7:0] fl,
			input logic [7:0] sg, input logic [15:0] sz);
		page_report_t r;
		r.status = st;
		r.offset = 32'(off);
		r.flags  = fl;
		r.segs   = sg;
		r.size   = sz;
		return r;
	endfunction

	function automatic page_report_t close_page();
		if (lace_total == 16'd0) begin
			walk_phase = opw_pkg::PH_HEADER;
		end else begin
			walk_phase = opw_pkg::PH_PAYLOAD;
		end
		phase_bytes = 16'd0;
		return make_report(opw_pkg::ST_PAGE, page_base, held_flags, held_segs,
			lace_total);
	endfunction

	function automatic logic [7:0] capture_char(input logic [1:0] idx);
		case (idx)
			2'd0: return opw_pkg::CHAR_O;
			2'd3: return opw_pkg::CHAR_S;
			default: return opw_pkg::CHAR_G;
		endcase
	endfunction

	// one request through the walker; returns 1 when it yields a report
	function automatic bit walk_step(input logic [7:0] b, input logic eos,
			output page_report_t rep);
		rep = '0;
		if (walk_phase == opw_pkg::PH_ERROR) begin
			return 1'b0;
		end
		if (eos) begin
			rep = make_report((walk_phase == opw_pkg::PH_HEADER && phase_bytes == 16'd0) ?
				opw_pkg::ST_CLEAN : opw_pkg::ST_TRUNC, byte_offset, 8'd0, 8'd0, 16'd0);
			return 1'b1;
		end
		if (walk_phase == opw_pkg::PH_HEADER && phase_bytes == 16'd0) begin
			page_base = byte_offset;
		end
		byte_offset = byte_offset + 1'b1;
		case (walk_phase)
			opw_pkg::PH_HEADER: begin
				if (phase_bytes < 16'd4 && b != capture_char(phase_bytes[1:0])) begin
					walk_phase  = opw_pkg::PH_ERROR;
					phase_bytes = 16'd0;
					rep = make_report(opw_pkg::ST_BAD, page_base, 8'd0, 8'd0, 16'd0);
					return 1'b1;
				end
				if (phase_bytes == 16'(opw_pkg::HDR_FLAGS)) begin
					held_flags = b;
				end
				if (phase_bytes == 16'(opw_pkg::HDR_LAST)) begin
					held_segs  = b;
					lace_total = 16'd0;
					if (b == 8'd0) begin
						rep = close_page();
						return 1'b1;
					end
					walk_phase  = opw_pkg::PH_SEGMENTS;
					phase_bytes = 16'd0;
					return 1'b0;
				end
				phase_bytes++;
				return 1'b0;
			end
			opw_pkg::PH_SEGMENTS: begin
				lace_total = lace_total + 16'(b);
				phase_bytes++;
				if (phase_bytes >= 16'(held_segs)) begin
					rep = close_page();
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				phase_bytes++;
				if (phase_bytes >= lace_total) begin
					walk_phase  = opw_pkg::PH_HEADER;
					phase_bytes = 16'd0;
				end
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		page_report_t fresh;
		page_report_t oldest;
		if (!arst_n) begin
			reports_due.delete();
			walk_phase     = opw_pkg::PH_HEADER;
			phase_bytes    = 16'd0;
			byte_offset    = '0;
			page_base      = '0;
			held_flags     = 8'd0;
			held_segs      = 8'd0;
			lace_total     = 16'd0;
			mismatch_count = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					report_mismatch("result with nothing pending, offset", page_offset, 32'd0);
				end else begin
					oldest = reports_due.pop_front();
					if (status !== oldest.status)
						report_mismatch("status", 32'(status), 32'(oldest.status));
					if (page_offset !== oldest.offset)
						report_mismatch("page_offset", page_offset, oldest.offset);
					if (page_flags !== oldest.flags)
						report_mismatch("page_flags", 32'(page_flags), 32'(oldest.flags));
					if (segment_count !== oldest.segs)
						report_mismatch("segment_count", 32'(segment_count), 32'(oldest.segs));
					if (payload_size !== oldest.size)
						report_mismatch("payload_size", 32'(payload_size), 32'(oldest.size));
				end
			end
			if (in_valid && in_ready) begin
				if (walk_step(data_byte, end_of_stream, fresh)) begin
					reports_due.push_back(fresh);
				end
			end
			errors  <= mismatch_count;
			pending <= reports_due.size();
		end
	end

endmodule

>>> tb/sv/ogg_page_walker_core_test.sv
// ----------------------------------------------------------------------------
// ogg_page_walker_core_test
// Stream-level test of the Ogg page walker core.
// ----------------------------------------------------------------------------
// Feeds generated Ogg pages one byte per request: directed pages first (no
// segments, empty payload, full lacing values, end markers on and off page
// boundaries), then random pages with scattered end markers, and at last a
// broken capture pattern followed by requests that must be dropped. The
// sender runs in random bursts, the receiver stalls in changing patterns;
// the checker beside the core does all prediction and comparison.
module ogg_page_walker_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 1250;
	localparam int CYCLE_LIMIT     = 2_000_000;
	localparam int DRAIN_CYCLES    = 32;

	typedef enum {LACE_MIXED, LACE_SMALL, LACE_ZERO, LACE_FULL} lace_kind_t;
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_QUARTER} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        end_of_stream;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] page_offset;
	logic [7:0]  page_flags;
	logic [7:0]  segment_count;
	logic [15:0] payload_size;

	int         fail_count;
	int         pending_count;
	int         cycle_count = 0;
	int         rx_tick = 0;
	int         burst_left = 0;
	int         requests_sent = 0;
	rx_mode_t   rx_mode = RX_OPEN;
	logic [7:0] page_bytes[$];

	ogg_page_walker_core dut (.*);

	ogg_page_walker_core_check page_check (
		.*,
		.errors  (fail_count),
		.pending (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ogg_page_walker_core_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 48 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= (rx_tick % 4 != 0);
		endcase
	end

	task automatic put_request(input logic [7:0] b, input logic eos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 24);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		requests_sent++;
	endtask

	// capture pattern, version, flags, 20 unchecked bytes, count, table, body
	function automatic void build_page(input logic [7:0] flags, input int segs,
			input lace_kind_t kind);
		int         body;
		int         pick;
		logic [7:0] lace;
		body = 0;
		page_bytes.delete();
		page_bytes.push_back(opw_pkg::CHAR_O);
		page_bytes.push_back(opw_pkg::CHAR_G);
		page_bytes.push_back(opw_pkg::CHAR_G);
		page_bytes.push_back(opw_pkg::CHAR_S);
		page_bytes.push_back(8'($urandom));
		page_bytes.push_back(flags);
		repeat (20) page_bytes.push_back(8'($urandom));
		page_bytes.push_back(8'(segs));
		repeat (segs) begin
			case (kind)
				LACE_FULL:  lace = 8'hFF;
				LACE_ZERO:  lace = 8'h00;
				LACE_SMALL: lace = 8'($urandom_range(0, 2));
				default: begin
					pick = $urandom_range(0, 99);
					lace = (pick < 8) ? 8'hFF : (pick < 23) ? 8'h00 :
						8'($urandom_range(1, 8));
				end
			endcase
			body += lace;
			page_bytes.push_back(lace);
		end
		repeat (body) page_bytes.push_back(8'($urandom));
	endfunction

	task automatic send_page(input int eos_pct);
		foreach (page_bytes[i]) begin
			if ($urandom_range(0, 99) < eos_pct)
				put_request(8'($urandom), 1'b1);
			put_request(page_bytes[i], 1'b0);
		end
	endtask

	initial begin
		int         random_start;
		int         pick;
		int         segs;
		int         bad_at;
		lace_kind_t kind;

		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		data_byte     <= 8'd0;
		end_of_stream <= 1'b0;
		out_ready     <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// end markers before any byte, repeated
		put_request(8'hFF, 1'b1);
		put_request(8'h00, 1'b1);
		build_page(8'h00, 0, LACE_ZERO);
		send_page(0);
		build_page(8'hFF, 1, LACE_ZERO);
		send_page(0);
		build_page(8'h01, 4, LACE_MIXED);
		send_page(10);
		put_request(8'h5A, 1'b1);
		build_page(8'h06, 1, LACE_FULL);
		send_page(0);
		build_page(8'h04, 255, LACE_ZERO);
		send_page(0);

		random_start = requests_sent;
		while (requests_sent - random_start < RANDOM_REQUESTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				segs = 0;
				kind = LACE_MIXED;
			end else if (pick < 16) begin
				segs = 255;
				kind = LACE_SMALL;
			end else begin
				segs = $urandom_range(1, 6);
				kind = LACE_MIXED;
			end
			build_page(8'($urandom), segs, kind);
			send_page(2);
			if ($urandom_range(0, 9) == 0)
				put_request(8'($urandom), 1'b1);
		end

		// broken capture pattern; everything after it is dropped
		build_page(8'($urandom), 1, LACE_SMALL);
		bad_at = $urandom_range(0, 3);
		page_bytes[bad_at] = page_bytes[bad_at] ^ 8'($urandom_range(1, 255));
		for (int i = 0; i <= bad_at; i++)
			put_request(page_bytes[i], 1'b0);
		repeat (16) put_request(8'($urandom), 1'($urandom_range(0, 1)));
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("ogg_page_walker_core_test: done, clean");
		end else begin
			$display("ogg_page_walker_core_test: done, errors");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/opw_pkg.sv
hw/rtl/opw_front.sv
hw/rtl/opw_queue.sv
hw/rtl/opw_back.sv
hw/rtl/ogg_page_walker_core.sv
tb/sv/ogg_page_walker_core_check.sv
tb/sv/ogg_page_walker_core_test.sv
